>>> design/ged_pkg.sv
// Shared types, register codes and helpers for the grayscale erode/dilate window.
// No dependencies; the window cell, the core and the bench import this package.
package ged_pkg;

  localparam int PIX_W = 8;
  localparam int SAMPLE_W = PIX_W + 1;
  localparam int SE_BITS = 49;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 49;

  localparam int DEF_MAX_HALF_FAST = 3;
  localparam int DEF_MAX_HALF_SLOW = 3;
  localparam int DEF_MAX_LINE = 1024;

  localparam logic [SE_BITS-1:0] RST_SE_MASK = SE_BITS'(1);
  localparam logic [10:0] RST_LINE_LENGTH = 11'd1024;
  localparam logic [15:0] RST_LINE_COUNT = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SE_MASK     = 3'd0,
    CFG_HALF_FAST   = 3'd1,
    CFG_HALF_SLOW   = 3'd2,
    CFG_LINE_LENGTH = 3'd3,
    CFG_LINE_COUNT  = 3'd4,
    CFG_MASK_ENABLE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             mask_bit;
  } ged_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] eroded_value;
    logic [PIX_W-1:0] dilated_value;
    logic             last_result;
  } ged_out_t;

  typedef struct packed {
    logic shift;
    logic reduce;
  } ged_cell_ctl_t;

  // Structuring-element select for the cell that holds column delay j, row delay d.
  function automatic logic se_sel(input logic [SE_BITS-1:0] mask, input int hf, input int hs,
                                  input int j, input int d);
    int fx;
    int fy;
    int k;
    fx = 2 * hf - j;
    fy = 2 * hs - d;
    k = fx + (2 * hf + 1) * fy;
    if (fx < 0 || fy < 0 || k >= SE_BITS) begin
      return 1'b0;
    end
    return mask[k];
  endfunction

endpackage

>>> design/ged_line_bank.sv
// One line store bank: single write port, single registered read port.
// Depends on nothing outside itself.
module ged_line_bank #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int W = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata_r
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> design/ged_window_cell.sv
// Window cell: holds one column of samples, passes it on, and reduces it to min/max.
// Depends on ged_pkg.
module ged_window_cell import ged_pkg::*; #(
  parameter int ROWS = 7
) (
  input  logic                clk,
  input  ged_cell_ctl_t       ctl,
  input  logic [SAMPLE_W-1:0] col_in [ROWS],
  input  logic [ROWS-1:0]     sel,
  output logic [SAMPLE_W-1:0] col_r [ROWS],
  output logic [PIX_W-1:0]    lo_r,
  output logic [PIX_W-1:0]    hi_r
);

  logic [PIX_W-1:0] lo_nxt;
  logic [PIX_W-1:0] hi_nxt;

  always_comb begin
    lo_nxt = '1;
    hi_nxt = '0;
    for (int d = 0; d < ROWS; d++) begin
      if (sel[d] && col_r[d][PIX_W-1:0] < lo_nxt) begin
        lo_nxt = col_r[d][PIX_W-1:0];
      end
      if (sel[d] && col_r[d][PIX_W-1:0] > hi_nxt) begin
        hi_nxt = col_r[d][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_r <= col_in;
    end
    if (ctl.reduce) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

>>> design/gray_erode_dilate_window_core.sv
// Top level of the grayscale erode/dilate window: config, raster counters, line banks,
// cell chain and result register. Depends on ged_pkg, ged_line_bank, ged_window_cell.
//
//   channel   ports                          direction
//   in        in_valid, in_ready, in_data    pixel + mask bit request in
//   out       out_valid, out_ready, out_data eroded, dilated, last out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data   register write in
//
// One pixel per cycle while the output is not stalled; out_valid follows its causing pixel
// through the bank read at the accept edge, then cell shift, column reduce and window
// combine into the output register.
// Each line bank has one write and one read port, which sets the one-pixel-per-cycle rate.
// Reset (synchronous, rst_n low) clears config, counters and valids, not data or line banks.
// A stalled output holds the whole pipeline; in_ready drops only while the result waits.
module gray_erode_dilate_window_core import ged_pkg::*; #(
  parameter int MAX_HALF_FAST = DEF_MAX_HALF_FAST,
  parameter int MAX_HALF_SLOW = DEF_MAX_HALF_SLOW,
  parameter int MAX_LINE = DEF_MAX_LINE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ged_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ged_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WF = 2 * MAX_HALF_FAST + 1;
  localparam int WS = 2 * MAX_HALF_SLOW + 1;
  localparam int XW = $clog2(MAX_LINE);
  localparam int BIW = $clog2(WS);
  localparam int CIW = $clog2(WF);
  localparam int HFW = $clog2(MAX_HALF_FAST + 1);
  localparam int HSW = $clog2(MAX_HALF_SLOW + 1);

  // configuration
  logic [SE_BITS-1:0] se_mask_r;
  logic [1:0]         half_fast_r;
  logic [1:0]         half_slow_r;
  logic [10:0]        line_length_r;
  logic [15:0]        line_count_r;
  logic               mask_enable_r;
  logic               cfg_we;
  logic               geo_write;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_mask_r     <= RST_SE_MASK;
      half_fast_r   <= '0;
      half_slow_r   <= '0;
      line_length_r <= RST_LINE_LENGTH;
      line_count_r  <= RST_LINE_COUNT;
      mask_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SE_MASK:     se_mask_r     <= cfg_data[SE_BITS-1:0];
        CFG_HALF_FAST:   half_fast_r   <= cfg_data[1:0];
        CFG_HALF_SLOW:   half_slow_r   <= cfg_data[1:0];
        CFG_LINE_LENGTH: line_length_r <= cfg_data[10:0];
        CFG_LINE_COUNT:  line_count_r  <= cfg_data[15:0];
        CFG_MASK_ENABLE: mask_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index) inside
      CFG_HALF_FAST, CFG_HALF_SLOW, CFG_LINE_LENGTH, CFG_LINE_COUNT: geo_write = cfg_we;
      default: geo_write = 1'b0;
    endcase
  end

  // saturated geometry
  logic [HFW-1:0] hf_eff;
  logic [HSW-1:0] hs_eff;
  logic [XW:0]    len_eff;
  logic [15:0]    cnt_eff;

  always_comb begin
    hf_eff = (32'(half_fast_r) > MAX_HALF_FAST) ? HFW'(MAX_HALF_FAST) : HFW'(half_fast_r);
    hs_eff = (32'(half_slow_r) > MAX_HALF_SLOW) ? HSW'(MAX_HALF_SLOW) : HSW'(half_slow_r);
    if (line_length_r == '0) begin
      len_eff = (XW+1)'(1);
    end else if (32'(line_length_r) > MAX_LINE) begin
      len_eff = (XW+1)'(MAX_LINE);
    end else begin
      len_eff = (XW+1)'(line_length_r);
    end
    cnt_eff = (line_count_r == '0) ? 16'd1 : line_count_r;
  end

  // raster position and ring pointer
  logic [XW-1:0]  x_r;
  logic [15:0]    y_r;
  logic [BIW-1:0] wp_r;
  logic           en;
  logic           accept;
  logic           x_end;
  logic           y_end;
  logic           produce;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign accept = in_valid && in_ready;
  assign x_end = (32'(x_r) == 32'(len_eff) - 1);
  assign y_end = (32'(y_r) == 32'(cnt_eff) - 1);
  assign produce = (32'(x_r) >= 2 * 32'(hf_eff)) && (32'(y_r) >= 2 * 32'(hs_eff));

  always_ff @(posedge clk) begin
    if (!rst_n || geo_write) begin
      x_r  <= '0;
      y_r  <= '0;
      wp_r <= '0;
    end else if (accept) begin
      if (x_end) begin
        x_r <= '0;
        if (y_end) begin
          y_r  <= '0;
          wp_r <= '0;
        end else begin
          y_r  <= y_r + 16'd1;
          wp_r <= (32'(wp_r) == WS - 1) ? '0 : wp_r + BIW'(1);
        end
      end else begin
        x_r <= x_r + XW'(1);
      end
    end
  end

  // line banks, one per ring line
  logic [SAMPLE_W-1:0] rdata [WS];

  for (genvar b = 0; b < WS; b++) begin : g_bank
    ged_line_bank #(
      .DEPTH (MAX_LINE),
      .AW    (XW),
      .W     (SAMPLE_W)
    ) u_bank (
      .clk     (clk),
      .we      (accept && (32'(wp_r) == b)),
      .waddr   (x_r),
      .wdata   ({in_data.mask_bit, in_data.pixel}),
      .re      (accept),
      .raddr   (x_r),
      .rdata_r (rdata[b])
    );
  end

  // pipeline control
  logic                s1_v_r;
  logic                s1_prod_r;
  logic                s1_last_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [BIW-1:0]      s1_wp_r;
  logic                s2_v_r;
  logic                s2_last_r;
  logic                s3_v_r;
  logic                s3_last_r;
  logic                s3_pass_r;
  logic [PIX_W-1:0]    s3_centre_r;
  logic                out_valid_r;
  ged_out_t            out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r && s1_prod_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_r   <= produce;
      s1_last_r   <= x_end && y_end;
      s1_sample_r <= {in_data.mask_bit, in_data.pixel};
      s1_wp_r     <= wp_r;
    end
  end

  // new column: current pixel on top, older lines below
  logic [SAMPLE_W-1:0] col_new [WS];

  always_comb begin
    int idx;
    col_new[0] = s1_sample_r;
    for (int d = 1; d < WS; d++) begin
      idx = 32'(s1_wp_r) + WS - d;
      if (idx >= WS) begin
        idx = idx - WS;
      end
      col_new[d] = rdata[BIW'(idx)];
    end
  end

  // cell chain
  ged_cell_ctl_t       cell_ctl;
  logic [SAMPLE_W-1:0] cell_in [WF][WS];
  logic [SAMPLE_W-1:0] cell_col [WF][WS];
  logic [PIX_W-1:0]    cell_lo [WF];
  logic [PIX_W-1:0]    cell_hi [WF];
  logic [WS-1:0]       cell_sel [WF];

  assign cell_ctl.shift  = en && s1_v_r;
  assign cell_ctl.reduce = en && s2_v_r;

  always_comb begin
    for (int j = 0; j < WF; j++) begin
      for (int d = 0; d < WS; d++) begin
        cell_sel[j][d] = se_sel(se_mask_r, int'(hf_eff), int'(hs_eff), j, d);
      end
    end
  end

  // first cell takes the new column, every other cell its neighbor's
  always_comb begin
    cell_in[0] = col_new;
    for (int j = 1; j < WF; j++) begin
      cell_in[j] = cell_col[j-1];
    end
  end

  for (genvar j = 0; j < WF; j++) begin : g_cell
    ged_window_cell #(
      .ROWS (WS)
    ) u_cell (
      .clk    (clk),
      .ctl    (cell_ctl),
      .col_in (cell_in[j]),
      .sel    (cell_sel[j]),
      .col_r  (cell_col[j]),
      .lo_r   (cell_lo[j]),
      .hi_r   (cell_hi[j])
    );
  end

  logic [SAMPLE_W-1:0] centre;
  assign centre = cell_col[CIW'(hf_eff)][BIW'(hs_eff)];

  always_ff @(posedge clk) begin
    if (cell_ctl.shift) begin
      s2_last_r <= s1_last_r;
    end
    if (cell_ctl.reduce) begin
      s3_last_r   <= s2_last_r;
      s3_centre_r <= centre[PIX_W-1:0];
      s3_pass_r   <= mask_enable_r && !centre[PIX_W];
    end
  end

  // combine columns with the centre
  ged_out_t out_nxt;

  always_comb begin
    out_nxt.eroded_value  = s3_centre_r;
    out_nxt.dilated_value = s3_centre_r;
    out_nxt.last_result   = s3_last_r;
    if (!s3_pass_r) begin
      for (int j = 0; j < WF; j++) begin
        if (cell_lo[j] < out_nxt.eroded_value) begin
          out_nxt.eroded_value = cell_lo[j];
        end
        if (cell_hi[j] > out_nxt.dilated_value) begin
          out_nxt.dilated_value = cell_hi[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_v_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    32'(x_r) < 32'(len_eff)) else $error("fast position beyond line length");

  a_ring_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < WS) else $error("ring pointer out of range");

  a_stage_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_v_r) |=> s3_v_r) else $error("reduced window lost");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.eroded_value <= out_data_r.dilated_value))
    else $error("erosion above dilation");
`endif

endmodule

>>> sim/gray_erode_dilate_window_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for gray_erode_dilate_window_core: raster pixel driver, result monitor
// and a software window min/max predictor. Depends on ged_pkg and the core RTL.
module gray_erode_dilate_window_core_tb;
  import ged_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int RING = 7;
  localparam int LINE_MAX = 1024;
  localparam int SETTLE = 10;
  localparam int WATCHDOG = 5000;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ged_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ged_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gray_erode_dilate_window_core DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: line ring, raster position and register copies.
  logic [SAMPLE_W-1:0] line_ring [RING][LINE_MAX];
  int unsigned fast_pos, slow_pos;
  logic [SE_BITS-1:0] se_bits;
  logic [1:0] win_hf, win_hs;
  logic [10:0] img_len;
  logic [15:0] img_lines;
  logic mask_on;

  ged_in_t pixel_queue[$];
  ged_out_t pending_windows[$];
  int errors = 0;
  int pixels_sent = 0;
  int windows_seen = 0;
  int phases = 0;
  logic hold_armed = 1'b0;

  function automatic void predict_window(ged_in_t d);
    int unsigned len, cnt, x, y, hf, hs, cx, cy, k, row;
    logic [SAMPLE_W-1:0] c;
    logic [PIX_W-1:0] lo, hi, v;
    ged_out_t r;
    len = (img_len == 0) ? 1 : (img_len > LINE_MAX ? LINE_MAX : img_len);
    cnt = (img_lines == 0) ? 1 : img_lines;
    hf = win_hf;
    hs = win_hs;
    x = (fast_pos >= len) ? 0 : fast_pos;
    y = (slow_pos >= cnt) ? 0 : slow_pos;
    line_ring[y % RING][x] = {d.mask_bit, d.pixel};
    if (x >= 2 * hf && y >= 2 * hs) begin
      cx = x - hf;
      cy = y - hs;
      c = line_ring[cy % RING][cx];
      lo = c[PIX_W-1:0];
      hi = lo;
      if (!(mask_on && !c[PIX_W])) begin
        for (int fy = 0; fy <= 2 * hs; fy++) begin
          row = (cy - hs + fy) % RING;
          for (int fx = 0; fx <= 2 * hf; fx++) begin
            k = fx + (2 * hf + 1) * fy;
            v = line_ring[row][cx - hf + fx][PIX_W-1:0];
            if (k < SE_BITS && se_bits[k]) begin
              if (v < lo) lo = v;
              if (v > hi) hi = v;
            end
          end
        end
      end
      r.eroded_value = lo;
      r.dilated_value = hi;
      r.last_result = (x == len - 1 && y == cnt - 1);
      pending_windows.push_back(r);
    end
    x++;
    if (x >= len) begin
      x = 0;
      y++;
      if (y >= cnt) y = 0;
    end
    fast_pos = x;
    slow_pos = y;
  endfunction

  // Pixel driver: one request per queue entry, random gap drawn per pixel.
  int send_gap = 0;
  logic send_burst = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_window(in_data);
        pixels_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the request
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_data <= pixel_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) send_burst <= ~send_burst;
        send_gap <= send_burst ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and output back-pressure.
  int take_gap = 0;
  int hold_left = 0;
  logic take_burst = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        int g;
        windows_seen++;
        if (pending_windows.size() == 0) begin
          $error("unexpected result %p", out_data);
          errors++;
        end else begin
          ged_out_t e;
          e = pending_windows.pop_front();
          if (out_data.eroded_value !== e.eroded_value) begin
            $error("eroded_value: expected %0d, got %0d", e.eroded_value, out_data.eroded_value);
            errors++;
          end
          if (out_data.dilated_value !== e.dilated_value) begin
            $error("dilated_value: expected %0d, got %0d", e.dilated_value,
                   out_data.dilated_value);
            errors++;
          end
          if (out_data.last_result !== e.last_result) begin
            $error("last_result: expected %0d, got %0d", e.last_result, out_data.last_result);
            errors++;
          end
        end
        if ($urandom_range(0, 63) == 0) take_burst <= ~take_burst;
        g = take_burst ? 0 : $urandom_range(0, 5);
        // zero gap keeps ready up for back-to-back results
        take_gap <= (g == 0) ? 0 : g - 1;
        out_ready <= (g == 0);
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_armed && out_valid) begin
        // stall long enough to back the pipeline up into in_ready
        hold_armed <= 1'b0;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // idle between writes so back-to-back writes never collide on cfg_valid
    @(posedge clk);
    case (idx)
      CFG_SE_MASK:     se_bits = val;
      CFG_HALF_FAST:   win_hf = val[1:0];
      CFG_HALF_SLOW:   win_hs = val[1:0];
      CFG_LINE_LENGTH: img_len = val[10:0];
      CFG_LINE_COUNT:  img_lines = val[15:0];
      CFG_MASK_ENABLE: mask_on = val[0];
      default: ;
    endcase
    if (idx inside {CFG_HALF_FAST, CFG_HALF_SLOW, CFG_LINE_LENGTH, CFG_LINE_COUNT}) begin
      fast_pos = 0;
      slow_pos = 0;
    end
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || pending_windows.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(int hf, int hs, int len, int cnt, logic [SE_BITS-1:0] se,
                              logic men);
    write_reg(CFG_SE_MASK, se);
    write_reg(CFG_HALF_FAST, CFG_DATA_W'(hf));
    write_reg(CFG_HALF_SLOW, CFG_DATA_W'(hs));
    write_reg(CFG_LINE_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_LINE_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_MASK_ENABLE, CFG_DATA_W'(men));
    phases++;
  endtask

  function automatic ged_in_t rand_pixel();
    ged_in_t p;
    case ($urandom_range(0, 7))
      0: p.pixel = 8'd0;
      1: p.pixel = 8'hFF;
      default: p.pixel = 8'($urandom_range(0, 255));
    endcase
    p.mask_bit = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic logic [SE_BITS-1:0] rand_se();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SE_BITS'({$urandom, $urandom});
    endcase
  endfunction

  initial begin
    int hf, hs, len, cnt, n;
    se_bits = RST_SE_MASK;
    win_hf = 0;
    win_hs = 0;
    img_len = RST_LINE_LENGTH;
    img_lines = RST_LINE_COUNT;
    mask_on = 1'b0;
    fast_pos = 0;
    slow_pos = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 1x1 window, every pixel comes straight back.
    pixel_queue.push_back('{8'd0, 1'b0});
    pixel_queue.push_back('{8'hFF, 1'b1});
    pixel_queue.push_back('{8'h5A, 1'b0});
    drain();

    // 3x3 full element with masking, extremes and masked-off centres.
    set_geometry(1, 1, 4, 3, '1, 1'b1);
    for (int i = 0; i < 12; i++)
      pixel_queue.push_back('{(i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'(i * 17),
                             1'(i != 5)});
    drain();

    // Zero sizes saturate to a 1x1 image; spare indexes and upper data bits are ignored.
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    write_reg(CFG_LINE_LENGTH, 49'h1_0000_0000_0000);
    write_reg(CFG_LINE_COUNT, 49'h1_0000_0000_0000);
    write_reg(CFG_HALF_FAST, 49'h1_0000_0000_0004);
    write_reg(CFG_HALF_SLOW, 49'h1_0000_0000_0004);
    pixel_queue.push_back('{8'h11, 1'b1});
    pixel_queue.push_back('{8'hEE, 1'b0});
    drain();

    // Image smaller than the window: no result.
    set_geometry(3, 3, 5, 8, '1, 1'b0);
    repeat (6) pixel_queue.push_back(rand_pixel());
    drain();

    // Longest line, overlong length saturates to the line store size; stall the output once.
    set_geometry(3, 0, 2047, 1, rand_se(), 1'b0);
    hold_armed = 1'b1;
    repeat (LINE_MAX) pixel_queue.push_back(rand_pixel());
    drain();

    while (pixels_sent < 1700) begin
      hf = $urandom_range(0, 3);
      hs = $urandom_range(0, 3);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2 * hf + 1)
                                        : $urandom_range(2 * hf + 1, 16);
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2 * hs + 1)
                                        : $urandom_range(2 * hs + 1, 10);
      set_geometry(hf, hs, len, cnt, rand_se(), 1'($urandom_range(0, 1)));
      n = len * cnt * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) n = n + $urandom_range(0, len * cnt - 1);
      repeat (n) pixel_queue.push_back(rand_pixel());
      drain();
    end

    $display("Covered %0d configurations, %0d pixels in, %0d window results checked.",
             phases, pixels_sent, windows_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
